FILE: src/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types, widths and calendar helpers for the calendar clock tick unit.
// ----------------------------------------------------------------------------
package cct_pkg;

  localparam int YEAR_W     = 14;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int HOUR_W     = 5;
  localparam int MINUTE_W   = 6;
  localparam int WEEKDAY_W  = 3;
  localparam int WEEK_IO_W  = 16;
  localparam int MPT_W      = 6;

  localparam int WEEK_COUNT_WIDTH_DEF = 16;

  localparam logic [MPT_W-1:0] MPT_RESET = 6'd6;

  localparam int MIN_PER_HOUR    = 60;
  localparam int HOUR_PER_DAY    = 24;
  localparam int DAYS_PER_WEEK   = 7;
  localparam int MONTHS_PER_YEAR = 12;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;

  // year / 25 by reciprocal: floor(y * 5243 / 2^17) is exact below 2^14
  localparam int RECIP25_MUL   = 5243;
  localparam int RECIP25_SHIFT = 17;
  localparam int RECIP25_PW    = YEAR_W + 13;
  localparam int QUOT25_W      = RECIP25_PW - RECIP25_SHIFT;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t                opcode;
    logic [YEAR_W-1:0]      year;
    logic [MONTH_W-1:0]     month;
    logic [DAY_W-1:0]       day;
    logic [HOUR_W-1:0]      hour;
    logic [MINUTE_W-1:0]    minute;
    logic [WEEKDAY_W-1:0]   weekday;
    logic [WEEK_IO_W-1:0]   week;
  } item_t;

  typedef struct packed {
    logic [YEAR_W-1:0]      year;
    logic [MONTH_W-1:0]     month;
    logic [DAY_W-1:0]       day;
    logic [HOUR_W-1:0]      hour;
    logic [MINUTE_W-1:0]    minute;
    logic [WEEKDAY_W-1:0]   weekday;
    logic                   leap;
  } cal_state_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    len = 5'd31;
    if (m == MONTH_FEB) begin
      len = 5'd28;
    end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      len = 5'd30;
    end
    return len;
  endfunction

  // gregorian leap test; y % 100 == 0 exactly when y % 4 == 0 and y % 25 == 0
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [RECIP25_PW-1:0] prod;
    logic [QUOT25_W-1:0]   quot;
    logic [YEAR_W-1:0]     back;
    logic [YEAR_W-1:0]     rem;
    prod = RECIP25_PW'(y) * RECIP25_PW'(RECIP25_MUL);
    quot = prod[RECIP25_PW-1:RECIP25_SHIFT];
    back = YEAR_W'(quot) * YEAR_W'(25);
    rem  = y - back;
    if (rem == '0) begin
      return (y[3:0] == 4'd0);
    end
    return (y[1:0] == 2'd0);
  endfunction

endpackage

FILE: src/cct_in_stage.sv
// ----------------------------------------------------------------------------
// cct_in_stage
// Input register: captures one beat and holds it until the result stage takes it.
// ----------------------------------------------------------------------------
module cct_in_stage import cct_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t item_in,
  input  logic  take,
  output logic  item_valid_r,
  output item_t item_r
);

  logic item_valid_nxt;

  assign in_stall       = item_valid_r && !take;
  assign item_valid_nxt = in_stall ? 1'b1 : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= item_in;
    end
  end

endmodule

FILE: src/cct_advance.sv
// ----------------------------------------------------------------------------
// cct_advance
// Next calendar state for one beat: load, or tick with carry ripple.
// ----------------------------------------------------------------------------
module cct_advance import cct_pkg::*; #(
  parameter int WEEK_COUNT_WIDTH = WEEK_COUNT_WIDTH_DEF
) (
  input  item_t                       item,
  input  cal_state_t                  st,
  input  logic [WEEK_COUNT_WIDTH-1:0] week,
  input  logic [MPT_W-1:0]            mpt,
  output cal_state_t                  st_nxt,
  output logic [WEEK_COUNT_WIDTH-1:0] week_nxt
);

  logic [MINUTE_W:0]           sum;
  logic [1:0]                  carry;
  logic [MINUTE_W:0]           min_w;
  logic [HOUR_W:0]             hour_w;
  logic                        day_adv;
  logic [HOUR_W:0]             hour_adj;
  logic [DAY_W-1:0]            day1;
  logic [WEEKDAY_W:0]          wd_w;
  logic [DAY_W-1:0]            len;
  logic                        day_roll;
  logic [MONTH_W:0]            month_w;
  logic                        year_roll;
  logic [YEAR_W-1:0]           year_inc;
  logic                        leap_inc;
  logic                        leap_load;
  logic [WEEK_COUNT_WIDTH-1:0] week_load;
  cal_state_t                  tick_st;
  logic [WEEK_COUNT_WIDTH-1:0] tick_week;

  generate
    if (WEEK_COUNT_WIDTH <= WEEK_IO_W) begin : g_week_trunc
      assign week_load = item.week[WEEK_COUNT_WIDTH-1:0];
    end else begin : g_week_ext
      assign week_load = {{(WEEK_COUNT_WIDTH-WEEK_IO_W){1'b0}}, item.week};
    end
  endgenerate

  assign year_inc  = st.year + YEAR_W'(1);
  assign leap_inc  = is_leap(year_inc);
  assign leap_load = is_leap(item.year);

  always_comb begin
    // minute sum reaches 126 at most, so two carries at most
    sum = {1'b0, st.minute} + {1'b0, mpt};
    if (sum >= (MINUTE_W+1)'(2 * MIN_PER_HOUR)) begin
      carry = 2'd2;
      min_w = sum - (MINUTE_W+1)'(2 * MIN_PER_HOUR);
    end else if (sum >= (MINUTE_W+1)'(MIN_PER_HOUR)) begin
      carry = 2'd1;
      min_w = sum - (MINUTE_W+1)'(MIN_PER_HOUR);
    end else begin
      carry = 2'd0;
      min_w = sum;
    end

    hour_w   = {1'b0, st.hour} + (HOUR_W+1)'(carry);
    day_adv  = (hour_w >= (HOUR_W+1)'(HOUR_PER_DAY));
    hour_adj = day_adv ? (hour_w - (HOUR_W+1)'(HOUR_PER_DAY)) : hour_w;
    day1     = day_adv ? (st.day + DAY_W'(1)) : st.day;

    tick_week = week;
    wd_w      = {1'b0, st.weekday} + (WEEKDAY_W+1)'(day_adv);
    if (wd_w > (WEEKDAY_W+1)'(DAYS_PER_WEEK)) begin
      tick_st.weekday = WEEKDAY_W'(1);
      tick_week       = week + WEEK_COUNT_WIDTH'(1);
    end else begin
      tick_st.weekday = wd_w[WEEKDAY_W-1:0];
    end

    len = month_len(st.month) + DAY_W'((st.month == MONTH_FEB) && st.leap);
    day_roll = (day1 > len);
    if (day_roll) begin
      tick_st.day = DAY_W'(1);
      month_w     = {1'b0, st.month} + (MONTH_W+1)'(1);
    end else begin
      tick_st.day = day1;
      month_w     = {1'b0, st.month};
    end

    year_roll = (month_w > (MONTH_W+1)'(MONTHS_PER_YEAR));
    if (year_roll) begin
      tick_st.month = MONTH_W'(1);
      tick_st.year  = year_inc;
      tick_st.leap  = leap_inc;
    end else begin
      tick_st.month = month_w[MONTH_W-1:0];
      tick_st.year  = st.year;
      tick_st.leap  = st.leap;
    end

    tick_st.hour   = hour_adj[HOUR_W-1:0];
    tick_st.minute = min_w[MINUTE_W-1:0];

    unique case (item.opcode)
      OP_LOAD: begin
        st_nxt.year    = item.year;
        st_nxt.month   = item.month;
        st_nxt.day     = item.day;
        st_nxt.hour    = item.hour;
        st_nxt.minute  = item.minute;
        st_nxt.weekday = item.weekday;
        st_nxt.leap    = leap_load;
        week_nxt       = week_load;
      end
      OP_TICK: begin
        st_nxt   = tick_st;
        week_nxt = tick_week;
      end
      default: begin
        st_nxt   = tick_st;
        week_nxt = tick_week;
      end
    endcase
  end

endmodule

FILE: src/cct_result_stage.sv
// ----------------------------------------------------------------------------
// cct_result_stage
// Result register, which is also the calendar state, with its valid flag.
// ----------------------------------------------------------------------------
module cct_result_stage import cct_pkg::*; #(
  parameter int WEEK_COUNT_WIDTH = WEEK_COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_valid,
  input  cal_state_t                  st_nxt,
  input  logic [WEEK_COUNT_WIDTH-1:0] week_nxt,
  input  logic                        out_stall,
  output logic                        take,
  output logic                        out_valid_r,
  output cal_state_t                  st_r,
  output logic [WEEK_COUNT_WIDTH-1:0] week_r
);

  logic out_valid_nxt;

  assign take          = !out_valid_r || !out_stall;
  assign out_valid_nxt = take ? item_valid : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      st_r.year    <= '0;
      st_r.month   <= MONTH_W'(1);
      st_r.day     <= DAY_W'(1);
      st_r.hour    <= '0;
      st_r.minute  <= '0;
      st_r.weekday <= WEEKDAY_W'(1);
      st_r.leap    <= 1'b1;  // year zero is a leap year
      week_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take && item_valid) begin
        st_r   <= st_nxt;
        week_r <= week_nxt;
      end
    end
  end

endmodule

FILE: src/calendar_clock_tick_unit.sv
// ----------------------------------------------------------------------------
// calendar_clock_tick_unit
// Calendar clock advanced by tick beats, or set by load beats.
// ----------------------------------------------------------------------------
// pipeline: an accepted input beat is held in the input register, and its
//   result is registered in the result register; one beat per cycle while the
//   result side is not stalled, with a single next-state pass between the two
// reset: synchronous, clears both stages and sets 0000-01-01 00:00, weekday 1,
//   week 0, 6 minutes per tick
module calendar_clock_tick_unit import cct_pkg::*; #(
  parameter int WEEK_COUNT_WIDTH = WEEK_COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [MPT_W-1:0]      cfg_minutes_per_tick,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  logic [YEAR_W-1:0]     in_load_year,
  input  logic [MONTH_W-1:0]    in_load_month,
  input  logic [DAY_W-1:0]      in_load_day,
  input  logic [HOUR_W-1:0]     in_load_hour,
  input  logic [MINUTE_W-1:0]   in_load_minute,
  input  logic [WEEKDAY_W-1:0]  in_load_weekday,
  input  logic [WEEK_IO_W-1:0]  in_load_week,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [YEAR_W-1:0]     out_year_out,
  output logic [MONTH_W-1:0]    out_month_out,
  output logic [DAY_W-1:0]      out_day_out,
  output logic [HOUR_W-1:0]     out_hour_out,
  output logic [MINUTE_W-1:0]   out_minute_out,
  output logic [WEEKDAY_W-1:0]  out_weekday_out,
  output logic [WEEK_IO_W-1:0]  out_week_out,
  output logic                  out_leap_flag
);

  logic [MPT_W-1:0]            mpt_val_r;
  item_t                       item_in;
  item_t                       item_r;
  logic                        item_valid_r;
  logic                        take;
  cal_state_t                  st_r;
  cal_state_t                  st_nxt;
  logic [WEEK_COUNT_WIDTH-1:0] week_r;
  logic [WEEK_COUNT_WIDTH-1:0] week_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpt_val_r <= MPT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mpt_val_r <= cfg_minutes_per_tick;
      end
    end
  end

  assign item_in.opcode  = opcode_t'(in_opcode);
  assign item_in.year    = in_load_year;
  assign item_in.month   = in_load_month;
  assign item_in.day     = in_load_day;
  assign item_in.hour    = in_load_hour;
  assign item_in.minute  = in_load_minute;
  assign item_in.weekday = in_load_weekday;
  assign item_in.week    = in_load_week;

  cct_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .item_in      (item_in),
    .take         (take),
    .item_valid_r (item_valid_r),
    .item_r       (item_r)
  );

  cct_advance #(
    .WEEK_COUNT_WIDTH (WEEK_COUNT_WIDTH)
  ) u_adv (
    .item     (item_r),
    .st       (st_r),
    .week     (week_r),
    .mpt      (mpt_val_r),
    .st_nxt   (st_nxt),
    .week_nxt (week_nxt)
  );

  cct_result_stage #(
    .WEEK_COUNT_WIDTH (WEEK_COUNT_WIDTH)
  ) u_res (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid_r),
    .st_nxt      (st_nxt),
    .week_nxt    (week_nxt),
    .out_stall   (out_stall),
    .take        (take),
    .out_valid_r (out_valid),
    .st_r        (st_r),
    .week_r      (week_r)
  );

  assign out_year_out    = st_r.year;
  assign out_month_out   = st_r.month;
  assign out_day_out     = st_r.day;
  assign out_hour_out    = st_r.hour;
  assign out_minute_out  = st_r.minute;
  assign out_weekday_out = st_r.weekday;
  assign out_leap_flag   = st_r.leap;

  generate
    if (WEEK_COUNT_WIDTH >= WEEK_IO_W) begin : g_week_out_trunc
      assign out_week_out = week_r[WEEK_IO_W-1:0];
    end else begin : g_week_out_ext
      assign out_week_out = {{(WEEK_IO_W-WEEK_COUNT_WIDTH){1'b0}}, week_r};
    end
  endgenerate

endmodule

FILE: src/cct_checker.sv
// ----------------------------------------------------------------------------
// cct_checker
// Port-level checks for the calendar clock tick unit, bound to the top level.
// ----------------------------------------------------------------------------
module cct_checker import cct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_stall,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [YEAR_W-1:0]     out_year_out,
  input  logic [MONTH_W-1:0]    out_month_out,
  input  logic [DAY_W-1:0]      out_day_out,
  input  logic [HOUR_W-1:0]     out_hour_out,
  input  logic [MINUTE_W-1:0]   out_minute_out,
  input  logic [WEEKDAY_W-1:0]  out_weekday_out,
  input  logic [WEEK_IO_W-1:0]  out_week_out,
  input  logic                  out_leap_flag
);

  // a full result side is the only thing that holds back the input side
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result side can move");

  // a stalled result beat keeps its calendar value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_year_out)
      && $stable(out_month_out) && $stable(out_day_out) && $stable(out_hour_out)
      && $stable(out_minute_out) && $stable(out_weekday_out) && $stable(out_week_out)
      && $stable(out_leap_flag)))
    else $error("stalled result beat changed");

  // a year that is not a multiple of four is never flagged leap
  a_leap_mod4: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_year_out[1:0] != 2'd0)) |-> !out_leap_flag)
    else $error("leap flag set on a year not divisible by four");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind calendar_clock_tick_unit cct_checker u_cct_checker (.*);

FILE: tb/tb_calendar_clock_tick_unit.sv
// ----------------------------------------------------------------------------
// tb_calendar_clock_tick_unit
// Drives tick and load beats into the calendar clock unit, predicts every
// result beat with an independent calendar model and compares field by field,
// across several minutes-per-tick settings and sender/receiver idling mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_calendar_clock_tick_unit;
  import cct_pkg::*;

  localparam int WEEK_BITS    = WEEK_COUNT_WIDTH_DEF;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [HOUR_W-1:0]    hour;
    logic [MINUTE_W-1:0]  minute;
    logic [WEEKDAY_W-1:0] weekday;
    logic [WEEK_IO_W-1:0] week;
    logic                 leap;
  } reading_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [MPT_W-1:0]     cfg_minutes_per_tick;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_opcode;
  logic [YEAR_W-1:0]    in_load_year;
  logic [MONTH_W-1:0]   in_load_month;
  logic [DAY_W-1:0]     in_load_day;
  logic [HOUR_W-1:0]    in_load_hour;
  logic [MINUTE_W-1:0]  in_load_minute;
  logic [WEEKDAY_W-1:0] in_load_weekday;
  logic [WEEK_IO_W-1:0] in_load_week;
  logic                 out_valid;
  logic                 out_stall;
  logic [YEAR_W-1:0]    out_year_out;
  logic [MONTH_W-1:0]   out_month_out;
  logic [DAY_W-1:0]     out_day_out;
  logic [HOUR_W-1:0]    out_hour_out;
  logic [MINUTE_W-1:0]  out_minute_out;
  logic [WEEKDAY_W-1:0] out_weekday_out;
  logic [WEEK_IO_W-1:0] out_week_out;
  logic                 out_leap_flag;

  // calendar model state
  int unsigned          tick_minutes;
  int unsigned          cal_year;
  int unsigned          cal_month;
  int unsigned          cal_day;
  int unsigned          cal_hour;
  int unsigned          cal_minute;
  int unsigned          cal_weekday;
  logic [WEEK_BITS-1:0] cal_week;

  item_t    beats_to_send[$];
  reading_t readings_due[$];
  int       beats_queued;
  int       beats_taken;
  int       error_count;
  int       send_idle_pct;
  int       stall_pct;
  int       hold_requests;
  int       holds_served;
  int       hold_left;
  logic     in_accepted;
  item_t    drv_item;
  item_t    seen_item;
  reading_t due;

  calendar_clock_tick_unit #(
    .WEEK_COUNT_WIDTH(WEEK_BITS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_minutes_per_tick(cfg_minutes_per_tick),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_load_year        (in_load_year),
    .in_load_month       (in_load_month),
    .in_load_day         (in_load_day),
    .in_load_hour        (in_load_hour),
    .in_load_minute      (in_load_minute),
    .in_load_weekday     (in_load_weekday),
    .in_load_week        (in_load_week),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_year_out        (out_year_out),
    .out_month_out       (out_month_out),
    .out_day_out         (out_day_out),
    .out_hour_out        (out_hour_out),
    .out_minute_out      (out_minute_out),
    .out_weekday_out     (out_weekday_out),
    .out_week_out        (out_week_out),
    .out_leap_flag       (out_leap_flag)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic bit leap_year(input int unsigned y);
    if (y % 100 == 0) begin
      return (y % 400) == 0;
    end
    return (y % 4) == 0;
  endfunction

  // months outside 1..12 count as 31 days
  function automatic int unsigned days_in_month(input int unsigned m);
    case (m)
      2:              return 28;
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  task automatic advance_calendar(input item_t b);
    int unsigned sum;
    int unsigned carry;
    int unsigned mlen;
    reading_t    r;
    if (b.opcode == OP_LOAD) begin
      cal_year    = b.year;
      cal_month   = b.month;
      cal_day     = b.day;
      cal_hour    = b.hour;
      cal_minute  = b.minute;
      cal_weekday = b.weekday;
      cal_week    = WEEK_BITS'(b.week);
    end else begin
      sum        = cal_minute + tick_minutes;
      carry      = sum / MIN_PER_HOUR;
      cal_minute = sum - MIN_PER_HOUR * carry;
      cal_hour   = cal_hour + carry;
      if (cal_hour >= HOUR_PER_DAY) begin
        cal_hour    = cal_hour - HOUR_PER_DAY;
        cal_day     = (cal_day + 1) & 32'h1F;
        cal_weekday = cal_weekday + 1;
      end
      if (cal_weekday > DAYS_PER_WEEK) begin
        cal_weekday = 1;
        cal_week    = cal_week + 1'b1;
      end
      mlen = days_in_month(cal_month);
      if (cal_month == MONTH_FEB && leap_year(cal_year)) begin
        mlen = mlen + 1;
      end
      if (cal_day > mlen) begin
        cal_day   = 1;
        cal_month = cal_month + 1;
      end
      if (cal_month > MONTHS_PER_YEAR) begin
        cal_month = 1;
        cal_year  = (cal_year + 1) & 32'h3FFF;
      end
    end
    r.year    = YEAR_W'(cal_year);
    r.month   = MONTH_W'(cal_month);
    r.day     = DAY_W'(cal_day);
    r.hour    = HOUR_W'(cal_hour);
    r.minute  = MINUTE_W'(cal_minute);
    r.weekday = WEEKDAY_W'(cal_weekday);
    r.week    = WEEK_IO_W'(cal_week);
    r.leap    = leap_year(cal_year);
    readings_due.push_back(r);
  endtask

  task automatic flag_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      flag_error($sformatf("%s mismatch: got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic item_t tick_item();
    item_t b;
    b = item_t'({$urandom, $urandom});
    b.opcode = OP_TICK;
    return b;
  endfunction

  function automatic item_t load_item(input int unsigned y, input int unsigned mo,
                                      input int unsigned d, input int unsigned h,
                                      input int unsigned mi, input int unsigned wd,
                                      input int unsigned wk);
    item_t b;
    b.opcode  = OP_LOAD;
    b.year    = YEAR_W'(y);
    b.month   = MONTH_W'(mo);
    b.day     = DAY_W'(d);
    b.hour    = HOUR_W'(h);
    b.minute  = MINUTE_W'(mi);
    b.weekday = WEEKDAY_W'(wd);
    b.week    = WEEK_IO_W'(wk);
    return b;
  endfunction

  // mostly ticks; most loads land near day and month ends so carries keep happening
  function automatic item_t random_item();
    item_t       b;
    int unsigned pick;
    int unsigned y;
    int unsigned m;
    int unsigned last;
    pick = $urandom_range(99);
    if (pick < 72) begin
      return tick_item();
    end
    b = item_t'({$urandom, $urandom});
    b.opcode = OP_LOAD;
    if (pick < 94) begin
      case ($urandom_range(4))
        0:       y = $urandom_range(9999);
        1:       y = $urandom_range(99) * 100;
        2:       y = $urandom_range(24) * 400;
        3:       y = $urandom_range(2499) * 4;
        default: y = 16383 - $urandom_range(3);
      endcase
      m    = $urandom_range(12, 1);
      last = days_in_month(m) + ((m == MONTH_FEB && leap_year(y)) ? 1 : 0);
      b.year  = YEAR_W'(y);
      b.month = MONTH_W'(m);
      case ($urandom_range(4))
        0, 1:    b.day = DAY_W'(last);
        2:       b.day = DAY_W'(last - 1);
        default: b.day = DAY_W'($urandom_range(28, 1));
      endcase
      b.hour    = ($urandom_range(3) == 0) ? HOUR_W'($urandom_range(23)) : HOUR_W'(23);
      b.minute  = MINUTE_W'($urandom_range(59, 30));
      b.weekday = WEEKDAY_W'($urandom_range(7, 1));
    end
    return b;
  endfunction

  task automatic queue_beat(input item_t b);
    beats_to_send.push_back(b);
    beats_queued++;
  endtask

  task automatic queue_random(input int n);
    repeat (n) queue_beat(random_item());
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (beats_taken != beats_queued || readings_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_tick_minutes(input logic [MPT_W-1:0] v);
    @(negedge clk);
    cfg_valid            <= 1'b1;
    cfg_minutes_per_tick <= v;
    do @(posedge clk); while (!cfg_ready);
    tick_minutes = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // input driver: next beat only once the current one has been taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_accepted)) begin
      if (beats_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = beats_to_send.pop_front();
        in_opcode       <= drv_item.opcode;
        in_load_year    <= drv_item.year;
        in_load_month   <= drv_item.month;
        in_load_day     <= drv_item.day;
        in_load_hour    <= drv_item.hour;
        in_load_minute  <= drv_item.minute;
        in_load_weekday <= drv_item.weekday;
        in_load_week    <= drv_item.week;
        in_valid        <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side stall, with a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      out_stall    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: predict on each accepted input beat, check each accepted result beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_accepted <= 1'b0;
    end else begin
      in_accepted <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        seen_item.opcode  = opcode_t'(in_opcode);
        seen_item.year    = in_load_year;
        seen_item.month   = in_load_month;
        seen_item.day     = in_load_day;
        seen_item.hour    = in_load_hour;
        seen_item.minute  = in_load_minute;
        seen_item.weekday = in_load_weekday;
        seen_item.week    = in_load_week;
        advance_calendar(seen_item);
        beats_taken++;
      end
      if (out_valid && !out_stall) begin
        if (readings_due.size() == 0) begin
          flag_error("result beat with no expected reading");
        end else begin
          due = readings_due.pop_front();
          check_field("year", out_year_out, due.year);
          check_field("month", out_month_out, due.month);
          check_field("day", out_day_out, due.day);
          check_field("hour", out_hour_out, due.hour);
          check_field("minute", out_minute_out, due.minute);
          check_field("weekday", out_weekday_out, due.weekday);
          check_field("week", out_week_out, due.week);
          check_field("leap", out_leap_flag, due.leap);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_calendar_clock_tick_unit: errors");
    $finish;
  end

  initial begin
    rst_n                = 1'b0;
    cfg_valid            = 1'b0;
    cfg_minutes_per_tick = MPT_RESET;
    in_valid             = 1'b0;
    in_opcode            = OP_TICK;
    in_load_year         = '0;
    in_load_month        = '0;
    in_load_day          = '0;
    in_load_hour         = '0;
    in_load_minute       = '0;
    in_load_weekday      = '0;
    in_load_week         = '0;
    out_stall            = 1'b0;
    beats_queued         = 0;
    beats_taken          = 0;
    error_count          = 0;
    send_idle_pct        = 0;
    stall_pct            = 0;
    hold_requests        = 0;
    holds_served         = 0;
    hold_left            = 0;
    tick_minutes         = MPT_RESET;
    cal_year             = 0;
    cal_month            = 1;
    cal_day              = 1;
    cal_hour             = 0;
    cal_minute           = 0;
    cal_weekday          = 1;
    cal_week             = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed beats at the reset setting of 6 minutes per tick
    @(posedge clk);
    queue_beat(tick_item());
    // last minutes of the year, with weekday and week count at their maxima
    queue_beat(load_item(9999, 12, 31, 23, 59, 7, 65535));
    queue_beat(tick_item());
    // end of a 30-day month, weekday and week count both wrap
    queue_beat(load_item(2023, 11, 30, 23, 58, 7, 65535));
    queue_beat(tick_item());
    // leap february, then its last day into march
    queue_beat(load_item(2024, 2, 28, 23, 57, 3, 10));
    queue_beat(tick_item());
    queue_beat(load_item(2024, 2, 29, 23, 59, 4, 10));
    queue_beat(tick_item());
    // century that is not a leap year, and one that is
    queue_beat(load_item(1900, 2, 28, 23, 59, 3, 20));
    queue_beat(tick_item());
    queue_beat(load_item(2000, 2, 28, 23, 59, 1, 30));
    queue_beat(tick_item());
    // feb 29 loaded in a common year rolls on the next tick
    queue_beat(load_item(2023, 2, 29, 10, 0, 3, 40));
    queue_beat(tick_item());
    // month past 12, first with the year at its top value
    queue_beat(load_item(16383, 13, 5, 12, 0, 5, 50));
    queue_beat(tick_item());
    queue_beat(load_item(100, 15, 31, 23, 59, 2, 60));
    queue_beat(tick_item());
    // month 0 with day 0 holding still
    queue_beat(load_item(2020, 0, 0, 5, 0, 5, 0));
    queue_beat(tick_item());
    // minute and hour loaded out of range, weekday 0
    queue_beat(load_item(2020, 5, 3, 31, 63, 0, 7));
    queue_beat(tick_item());
    queue_beat(load_item(2020, 6, 10, 23, 59, 0, 7));
    queue_beat(tick_item());
    queue_random(100);
    wait_drained();

    write_tick_minutes(MPT_W'(1));
    @(posedge clk);
    send_idle_pct = 84;
    stall_pct     = 0;
    queue_random(120);
    wait_drained();

    write_tick_minutes(MPT_W'(59));
    @(posedge clk);
    send_idle_pct = 0;
    stall_pct     = 84;
    hold_requests++;
    // minute sum past 120 gives two hour carries
    queue_beat(load_item(2020, 7, 7, 22, 63, 3, 1));
    queue_beat(tick_item());
    queue_random(120);
    wait_drained();

    write_tick_minutes(MPT_W'(0));
    @(posedge clk);
    send_idle_pct = 9;
    stall_pct     = 9;
    queue_random(120);
    wait_drained();

    write_tick_minutes(MPT_W'($urandom_range(59, 1)));
    @(posedge clk);
    send_idle_pct = 0;
    stall_pct     = 0;
    queue_random(140);
    wait_drained();

    if (error_count == 0) begin
      $display("tb_calendar_clock_tick_unit: clean");
    end else begin
      $display("tb_calendar_clock_tick_unit: errors");
    end
    $finish;
  end

endmodule

FILE: calendar_clock_tick_unit.f
src/cct_pkg.sv
src/cct_in_stage.sv
src/cct_advance.sv
src/cct_result_stage.sv
src/calendar_clock_tick_unit.sv
src/cct_checker.sv
tb/tb_calendar_clock_tick_unit.sv
